// ===== rtl/bolt_pkg.sv =====
// ----------------------------------------------------------------------------
// bolt_pkg: shared types and constants of the bounded open LRU tracker
// Field widths, event codes and the token and control structs that run
// along the recency chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bolt_pkg;

    localparam int CMD_W     = 1;
    localparam int ID_W      = 6;
    localparam int CNT_W     = 7;
    localparam int MAX_ITEMS = 2 ** ID_W;

    localparam logic [CMD_W-1:0] CMD_OPEN  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TOUCH = 1'b1;

    // token that walks down the chain, one cell per cycle
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] carry;
    } t_tok;

    // walk control, broadcast to every cell and held for the whole walk
    typedef struct packed {
        logic            touch;     // stop at the cell holding target
        logic [ID_W-1:0] target;
        logic [ID_W-1:0] stop_pos;  // insert: stop at this position
    } t_walk;

endpackage

`default_nettype wire

// ===== rtl/bounded_open_lru_tracker.sv =====
// ----------------------------------------------------------------------------
// bounded_open_lru_tracker: open-item tracker with LRU eviction under a cap
// Top level: event decode, open flags, count and the chain of list cells.
// ----------------------------------------------------------------------------
// Items are kept in a row of cells ordered from most recent (position 0) to
// least recent. An open of an unlisted item or any event on a listed one (cap
// nonzero) sends a token down the row, one cell per cycle, shifting ids by one
// place until it reaches the touched item, the free position, or, when the
// cap is exceeded, the tail, whose old id leaves as the evicted item. The
// position where the token stops is at most NUM_ITEMS - 1, capped at 63; an
// event that sends no token gives its result without a walk. One event is in
// flight at a time; the result sits in an output register, and the input is
// stalled while that result is held. The user writes open_limit through
// i_cfg_we / i_cfg_data while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_open_lru_tracker #(
    parameter int NUM_ITEMS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [bolt_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [bolt_pkg::ID_W-1:0]   i_item_id,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_evict_valid,
    output logic [bolt_pkg::ID_W-1:0]        o_evicted_id,
    output logic [bolt_pkg::CNT_W-1:0]       o_open_count,
    input  wire logic                        i_cfg_we,
    input  wire logic [bolt_pkg::CNT_W-1:0]  i_cfg_data
);
    import bolt_pkg::*;

    localparam int NCELL = (NUM_ITEMS < MAX_ITEMS) ? NUM_ITEMS : MAX_ITEMS;
    localparam int IW    = $clog2(NCELL);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic             r_state;
    logic [NCELL-1:0] r_flags;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_limit;
    logic             r_evict;
    t_tok             r_tok0;
    t_walk            r_walk;

    logic             r_ovalid;
    logic             r_oev;
    logic [ID_W-1:0]  r_oid;
    logic [CNT_W-1:0] r_ocnt;

    t_tok             w_tok [NCELL];
    logic             w_cell_done [NCELL];
    logic [ID_W-1:0]  w_cell_old [NCELL];
    logic             w_done;
    logic [ID_W-1:0]  w_old;

    logic             w_accept;
    logic             w_in_range;
    logic             w_listed;
    logic             w_insert;
    logic             w_move;
    logic             w_evict_req;
    logic             w_launch;
    logic             w_load;

    assign o_stall       = (r_state != ST_IDLE) || (r_ovalid && i_stall);
    assign o_valid       = r_ovalid;
    assign o_evict_valid = r_oev;
    assign o_evicted_id  = r_oid;
    assign o_open_count  = r_ocnt;

    assign w_accept    = i_valid && !o_stall;
    assign w_in_range  = int'(i_item_id) < NUM_ITEMS;
    assign w_listed    = w_in_range && r_flags[i_item_id[IW-1:0]];
    assign w_insert    = w_in_range && !r_flags[i_item_id[IW-1:0]] && (i_cmd == CMD_OPEN);
    assign w_move      = w_listed && (r_limit != '0);
    assign w_evict_req = (r_limit != '0) && ((r_count + CNT_W'(1)) > r_limit);

    // a walk starts, or a result is ready at this edge
    assign w_launch = (r_state == ST_IDLE) && w_accept && (w_move || w_insert);
    assign w_load   = ((r_state == ST_IDLE) && w_accept && !(w_move || w_insert))
                   || ((r_state == ST_WALK) && w_done);

    assign w_tok[0] = r_tok0;

    // the cell where the token stops reports its old id
    always_comb begin
        w_done = 1'b0;
        w_old  = '0;
        for (int k = 0; k < NCELL; k++) begin
            w_done = w_done | w_cell_done[k];
            w_old  = w_old | (w_cell_done[k] ? w_cell_old[k] : '0);
        end
    end

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k < NCELL - 1) begin : g_mid
            bolt_cell #(.POS(k)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (w_tok[k]),
                .i_walk   (r_walk),
                .o_tok    (w_tok[k+1]),
                .o_done   (w_cell_done[k]),
                .o_old_id (w_cell_old[k])
            );
        end else begin : g_last
            bolt_cell #(.POS(k)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (w_tok[k]),
                .i_walk   (r_walk),
                .o_tok    (),
                .o_done   (w_cell_done[k]),
                .o_old_id (w_cell_old[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_flags  <= '0;
            r_count  <= '0;
            r_limit  <= '0;
            r_evict  <= 1'b0;
            r_tok0   <= '0;
            r_walk   <= '0;
            r_ovalid <= 1'b0;
            r_oev    <= 1'b0;
            r_oid    <= '0;
            r_ocnt   <= '0;
        end else begin
            r_tok0.valid <= w_launch;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_move || w_insert) begin
                            r_tok0.carry   <= i_item_id;
                            r_walk.touch   <= w_move;
                            r_walk.target  <= i_item_id;
                            // with eviction the old tail takes the last shift
                            r_walk.stop_pos <= (w_insert && w_evict_req)
                                ? ID_W'(r_count - CNT_W'(1)) : ID_W'(r_count);
                            r_evict <= w_insert && w_evict_req;
                            if (w_insert) begin
                                r_flags[i_item_id[IW-1:0]] <= 1'b1;
                                if (!w_evict_req) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            r_state <= ST_WALK;
                        end else begin
                            r_oev    <= 1'b0;
                            r_oid    <= '0;
                            r_ocnt   <= r_count;
                        end
                    end
                end
                ST_WALK: begin
                    if (w_done) begin
                        if (r_evict) begin
                            r_flags[w_old[IW-1:0]] <= 1'b0;
                        end
                        r_oev    <= r_evict;
                        r_oid    <= r_evict ? w_old : '0;
                        r_ocnt   <= r_count;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bolt_cell.sv =====
// ----------------------------------------------------------------------------
// bolt_cell: one position of the recency list
// Holds one listed item. When the walking token arrives the cell stores the
// carried id and either hands its old id on to the next cell or ends the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module bolt_cell #(
    parameter int POS = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bolt_pkg::t_tok        i_tok,
    input  wire bolt_pkg::t_walk       i_walk,
    output bolt_pkg::t_tok             o_tok,
    output logic                       o_done,
    output logic [bolt_pkg::ID_W-1:0]  o_old_id
);
    import bolt_pkg::*;

    logic            r_valid;
    logic [ID_W-1:0] r_id;
    logic            r_tok_valid;
    logic [ID_W-1:0] r_tok_carry;
    logic            w_stop;

    assign w_stop = i_walk.touch ? (r_valid && (r_id == i_walk.target))
                                 : (ID_W'(POS) == i_walk.stop_pos);

    assign o_done   = i_tok.valid && w_stop;
    assign o_old_id = r_id;
    assign o_tok    = '{valid: r_tok_valid, carry: r_tok_carry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok.valid && !w_stop;
            if (i_tok.valid) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_carry <= r_id;
        if (i_tok.valid) begin
            r_id <= i_tok.carry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bolt_checker.sv =====
// ----------------------------------------------------------------------------
// bolt_checker: port-level checks of the bounded open LRU tracker
// Result consistency and output channel behavior, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bolt_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic                        o_evict_valid,
    input wire logic [bolt_pkg::ID_W-1:0]   o_evicted_id,
    input wire logic [bolt_pkg::CNT_W-1:0]  o_open_count
);
    import bolt_pkg::*;

    // no eviction reports id zero
    a_evict_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evict_valid |-> o_evicted_id == '0)
        else $error("evicted id nonzero without eviction");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_open_count <= CNT_W'(MAX_ITEMS))
        else $error("open count beyond item range");

    // the opened item stays listed, so an eviction never empties the list
    a_evict_keeps_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evict_valid |-> o_open_count != '0)
        else $error("eviction left no open item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_evict_valid)
            && $stable(o_evicted_id) && $stable(o_open_count))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind bounded_open_lru_tracker bolt_checker u_bolt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_evict_valid (o_evict_valid),
    .o_evicted_id  (o_evicted_id),
    .o_open_count  (o_open_count)
);

`default_nettype wire

// ===== tb/sv/bounded_open_lru_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_open_lru_tracker_tb: self-checking bench for the open LRU tracker
// Drives open and touch events under a series of caps, keeps its own copy of
// the open list and recency order, and checks every result transfer field by
// field. Sender bursts and receiver stalls are random; long output hold-offs are requested in two phases.
// ----------------------------------------------------------------------------

module bounded_open_lru_tracker_tb;
    import bolt_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int N_ITEMS        = 64;
    localparam int SETTLE_CYCLES  = 80;      // longer than the longest walk
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int N_PHASES       = 10;
    localparam int PHASE_ITEMS    = 150;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic             evict;
        logic [ID_W-1:0]  victim;
        logic [CNT_W-1:0] count;
    } t_lru_result;

    // open list, recency order and cap, plus the results still owed by the block
    class t_open_lru_scoreboard;
        bit          is_open[N_ITEMS];
        int          rank[N_ITEMS];
        int          n_open;
        int          cap;
        t_lru_result owed[$];
        int          errors;

        function new();
            foreach (is_open[i]) begin
                is_open[i] = 0;
                rank[i]    = 0;
            end
            n_open = 0;
            cap    = 0;
            errors = 0;
        endfunction

        function void set_cap(int value);
            cap = value;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function void promote(int idx);
            int r;
            r = rank[idx];
            for (int i = 0; i < N_ITEMS; i++)
                if (is_open[i] && rank[i] < r)
                    rank[i]++;
            rank[idx] = 0;
        endfunction

        // update the list for one accepted event and queue the result it owes
        function void apply_event(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
            t_lru_result res;
            int          victim;
            int          best_rank;
            res = '0;
            if (is_open[id]) begin
                // repeated open behaves as a touch
                if (cap != 0)
                    promote(id);
            end else if (cmd == CMD_OPEN) begin
                for (int i = 0; i < N_ITEMS; i++)
                    if (is_open[i])
                        rank[i]++;
                is_open[id] = 1;
                rank[id]    = 0;
                n_open++;
                if (cap != 0 && n_open > cap) begin
                    victim    = -1;
                    best_rank = -1;
                    for (int i = 0; i < N_ITEMS; i++)
                        if (i != id && is_open[i] && rank[i] > best_rank) begin
                            victim    = i;
                            best_rank = rank[i];
                        end
                    if (victim >= 0) begin
                        is_open[victim] = 0;
                        rank[victim]    = 0;
                        n_open--;
                        res.evict  = 1'b1;
                        res.victim = victim[ID_W-1:0];
                    end
                end
            end
            res.count = n_open[CNT_W-1:0];
            owed.push_back(res);
        endfunction

        function void check_result(t_lru_result got);
            t_lru_result exp;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result evict=%0d id=%0d count=%0d",
                             $time, got.evict, got.victim, got.count);
                return;
            end
            exp = owed.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch evict/id/count exp %0d/%0d/%0d got %0d/%0d/%0d",
                             $time, exp.evict, exp.victim, exp.count,
                             got.evict, got.victim, got.count);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [CMD_W-1:0] i_cmd;
    logic [ID_W-1:0]  i_item_id;
    logic             o_valid;
    logic             i_stall;
    logic             o_evict_valid;
    logic [ID_W-1:0]  o_evicted_id;
    logic [CNT_W-1:0] o_open_count;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    bit                   hold_req;
    t_open_lru_scoreboard sb = new();

    bounded_open_lru_tracker #(
        .NUM_ITEMS(N_ITEMS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_item_id    (i_item_id),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_evict_valid(o_evict_valid),
        .o_evicted_id (o_evicted_id),
        .o_open_count (o_open_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_evict_valid, o_evicted_id, o_open_count});
    end

    // receiver: random stall modes, long hold-off on request
    initial begin
        int mode;
        int len;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(16, 96);
            repeat (len) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req = 0;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                end else if (mode == 0) begin
                    i_stall <= 1'b0;
                end else if (mode == 1) begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end else begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("bounded_open_lru_tracker test failed");
        $finish;
    end

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_item_id <= id;
        do @(posedge i_clk); while (o_stall);
        sb.apply_event(cmd, id);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // stop offering, let every owed result arrive, then idle a while
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cap(input int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[CNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_cap(value);
    endtask

    initial begin
        int phase_cap[N_PHASES]  = '{1, 64, 12, 2, 0, 40, 3, 64, 5, 0};
        int phase_pool[N_PHASES] = '{4, 64, 16, 8, 64, 64, 8, 64, 16, 4};
        int sent;
        int burst;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cmd      = CMD_OPEN;
        i_item_id  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        hold_req   = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero cap: list grows, touches and double opens leave the order alone
        write_cap(0);
        send_event(CMD_OPEN, 0);
        send_event(CMD_OPEN, 63);
        send_event(CMD_TOUCH, 0);
        send_event(CMD_OPEN, 0);
        send_event(CMD_TOUCH, 5);
        send_event(CMD_TOUCH, 63);
        wait_drained();

        // small cap: evictions, touch reorders, touch of an evicted item
        write_cap(2);
        send_event(CMD_OPEN, 1);
        send_event(CMD_TOUCH, 63);
        send_event(CMD_OPEN, 42);
        send_event(CMD_OPEN, 63);
        send_event(CMD_TOUCH, 1);
        send_event(CMD_OPEN, 21);
        wait_drained();

        write_cap(64);
        send_event(CMD_OPEN, 7);
        send_event(CMD_OPEN, 56);
        send_event(CMD_OPEN, 0);
        send_event(CMD_TOUCH, 42);
        wait_drained();

        // cap below the count: each new open evicts one item, so the excess stays
        write_cap(1);
        send_event(CMD_OPEN, 9);
        send_event(CMD_OPEN, 10);
        send_event(CMD_TOUCH, 10);
        send_event(CMD_OPEN, 9);
        send_event(CMD_OPEN, 9);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            write_cap(phase_cap[p]);
            if (p == 2 || p == 6)
                hold_req = 1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    cmd = ($urandom_range(0, 99) < 45) ? CMD_TOUCH : CMD_OPEN;
                    if ($urandom_range(0, 9) == 0)
                        id = $urandom_range(0, N_ITEMS - 1);
                    else
                        id = $urandom_range(0, phase_pool[p] - 1);
                    send_event(cmd, id);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 6));
            end
            wait_drained();
        end

        if (sb.errors == 0)
            $display("bounded_open_lru_tracker test passed");
        else
            $display("bounded_open_lru_tracker test failed");
        $finish;
    end

endmodule
